// ===== hdl/fmrb_pkg.sv =====
`timescale 1ns / 1ps
package fmrb_pkg;

  // Ring geometry
  localparam int BUF_BYTES   = 1024;
  localparam int AW          = $clog2(BUF_BYTES);
  localparam int SIZE_W      = AW + 1;
  localparam int SIZE_MIN    = 16;
  localparam int FRAME_BYTES = 8;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int LEN_W    = 10;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 32;
  localparam int CFG_W    = 11;
  localparam int WORD_W   = 32;

  localparam logic [WORD_W-1:0] TRAILER = 32'hCDEF_FEDC;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_WBEGIN = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WBYTE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RBEGIN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RBYTE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CORRUPT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SEQ_ERR   = 3'd5;

  typedef enum logic [2:0] {
    OP_WBEGIN,
    OP_WBYTE,
    OP_RBEGIN,
    OP_RBYTE,
    OP_CLEAR,
    OP_BAD
  } op_code_t;

  // Classified item passed from front end to back end
  typedef struct packed {
    op_code_t              op;
    logic [LEN_W-1:0]      msg_length;
    logic [BYTE_W-1:0]     data_byte;
    logic [LEN_W-1:0]      reader_capacity;
  } op_t;

endpackage

// ===== hdl/fmrb_ifs.sv =====
`timescale 1ns / 1ps
interface fmrb_in_if;
  import fmrb_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [LEN_W-1:0]    msg_length;
  logic [BYTE_W-1:0]   data_byte;
  logic [LEN_W-1:0]    reader_capacity;

  modport source (output valid, cmd, msg_length, data_byte, reader_capacity, input ready);
  modport sink   (input valid, cmd, msg_length, data_byte, reader_capacity, output ready);
endinterface

interface fmrb_out_if;
  import fmrb_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   read_byte;
  logic [LEN_W-1:0]    length_out;
  logic                last_byte;
  logic [CNT_W-1:0]    written_count;
  logic [CNT_W-1:0]    read_count;

  modport source (output valid, status, read_byte, length_out, last_byte, written_count,
                  read_count, input ready);
  modport sink   (input valid, status, read_byte, length_out, last_byte, written_count,
                  read_count, output ready);
endinterface

// ===== hdl/framed_message_ring_buffer.sv =====
`timescale 1ns / 1ps
// Ring of single bytes holding whole framed messages (4-byte length, payload,
// 4-byte trailer). Commands enter through a one-stage front end and a
// two-entry queue, so the input can take items ahead while the back end
// works or a result waits, until both are full. The back end owns the ring
// memory (one write port, one registered read port) and runs one item at a
// time, then hands the result to the output register. write_begin writes the
// length bytes, a message is committed by writing the trailer, and a read is
// finished by reading and checking the trailer. Writing the size register
// clears the ring; there is no clearing pass over the memory.
module framed_message_ring_buffer (
  input  logic                         clk,
  input  logic                         rst_n,
  fmrb_in_if.sink                      in_ch,
  fmrb_out_if.source                   out_ch,
  input  logic                         cfg_wr_en,
  input  logic [fmrb_pkg::CFG_W-1:0]   cfg_wr_data
);
  import fmrb_pkg::*;

  op_t        fr_op;
  logic       fr_valid;
  logic       q_ready;
  op_t        q_op;
  logic       q_valid;
  logic       q_pop;
  logic [2:0] inflight_r, inflight_nxt;

  fmrb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .op       (fr_op),
    .op_valid (fr_valid),
    .op_ready (q_ready)
  );

  fmrb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (q_ready),
    .push_op    (fr_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_op     (q_op)
  );

  fmrb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_op        (q_op),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ch      (out_ch)
  );

  // Track items accepted but not yet delivered
  always_comb begin
    inflight_nxt = inflight_r;
    if ((in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready)) begin
      inflight_nxt = inflight_r + 3'd1;
    end else if (!(in_ch.valid && in_ch.ready) && (out_ch.valid && out_ch.ready)) begin
      inflight_nxt = inflight_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // No result without an item behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> inflight_r != 3'd0)
    else $error("result shown with no item in flight");

  // End of message only on ok or corrupt
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last_byte) |->
      (out_ch.status == ST_OK || out_ch.status == ST_CORRUPT))
    else $error("last_byte with unexpected status");

  // A corrupt ring is cleared, so both counts restart
  a_corrupt_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_CORRUPT) |->
      (out_ch.written_count == '0 && out_ch.read_count == '0))
    else $error("corrupt result without cleared counts");

endmodule

// ===== hdl/fmrb_front.sv =====
`timescale 1ns / 1ps
module fmrb_front (
  input  logic            clk,
  input  logic            rst_n,
  fmrb_in_if.sink         in_ch,
  output fmrb_pkg::op_t   op,
  output logic            op_valid,
  input  logic            op_ready
);
  import fmrb_pkg::*;

  logic     valid_r, valid_nxt;
  op_t      op_r;
  op_code_t code;

  // Decode the command into an operation
  always_comb begin
    unique case (in_ch.cmd)
      CMD_WBEGIN: code = OP_WBEGIN;
      CMD_WBYTE:  code = OP_WBYTE;
      CMD_RBEGIN: code = OP_RBEGIN;
      CMD_RBYTE:  code = OP_RBYTE;
      CMD_CLEAR:  code = OP_CLEAR;
      default:    code = OP_BAD;
    endcase
  end

  assign in_ch.ready = !valid_r || op_ready;

  // Hold the classified item until the queue takes it
  always_comb begin
    valid_nxt = valid_r;
    if (op_ready) begin
      valid_nxt = 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r.op              <= code;
      op_r.msg_length      <= in_ch.msg_length;
      op_r.data_byte       <= in_ch.data_byte;
      op_r.reader_capacity <= in_ch.reader_capacity;
    end
  end

  assign op       = op_r;
  assign op_valid = valid_r;

endmodule

// ===== hdl/fmrb_queue.sv =====
`timescale 1ns / 1ps
module fmrb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  fmrb_pkg::op_t   push_op,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fmrb_pkg::op_t   pop_op
);
  import fmrb_pkg::*;

  op_t        slot_r [2];
  logic       wr_idx_r, wr_idx_nxt;
  logic       rd_idx_r, rd_idx_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_op     = slot_r[rd_idx_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and count
  always_comb begin
    wr_idx_nxt = wr_idx_r ^ do_push;
    rd_idx_nxt = rd_idx_r ^ do_pop;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= 1'b0;
      rd_idx_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_idx_r] <= push_op;
    end
  end

endmodule

// ===== hdl/fmrb_back.sv =====
`timescale 1ns / 1ps
module fmrb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  fmrb_pkg::op_t                q_op,
  input  logic                         cfg_wr_en,
  input  logic [fmrb_pkg::CFG_W-1:0]   cfg_wr_data,
  fmrb_out_if.source                   out_ch
);
  import fmrb_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WHDR   = 3'd1;
  localparam logic [2:0] S_WTRL   = 3'd2;
  localparam logic [2:0] S_RHDR   = 3'd3;
  localparam logic [2:0] S_RBYTE  = 3'd4;
  localparam logic [2:0] S_RTRL   = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p,
                                             input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] q;
    q = {1'b0, p} + SIZE_W'(1);
    return (q >= sz) ? '0 : q[AW-1:0];
  endfunction

  // Control state
  logic [2:0]          state_r, state_nxt;
  logic [2:0]          k_r, k_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]       pw_r, pw_nxt;
  logic [AW-1:0]       pr_r, pr_nxt;
  logic [LEN_W-1:0]    wrem_r, wrem_nxt;
  logic [LEN_W-1:0]    rrem_r, rrem_nxt;
  logic                wact_r, wact_nxt;
  logic                ract_r, ract_nxt;
  logic [CNT_W-1:0]    mw_r, mw_nxt;
  logic [CNT_W-1:0]    mr_r, mr_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload state
  op_t                 cur_r, cur_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [BYTE_W-1:0]   res_byte_r, res_byte_nxt;
  logic [LEN_W-1:0]    res_lout_r, res_lout_nxt;
  logic                res_last_r, res_last_nxt;
  logic                load_out;
  logic [STATUS_W-1:0] out_status_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic [LEN_W-1:0]    out_lout_r;
  logic                out_last_r;
  logic [CNT_W-1:0]    out_wcnt_r;
  logic [CNT_W-1:0]    out_rcnt_r;

  // Ring memory
  logic [BYTE_W-1:0]   mem [BUF_BYTES];
  logic [BYTE_W-1:0]   rd_data_r;
  logic                mem_we;
  logic [BYTE_W-1:0]   mem_wdata;

  logic [SIZE_W-1:0]   room;
  logic [SIZE_W-1:0]   stored;
  logic [WORD_W-1:0]   word_full;
  logic [LEN_W-1:0]    wrem_dec;
  logic [LEN_W-1:0]    rrem_dec;
  logic [SIZE_W-1:0]   new_size;
  logic                do_clear;

  // Free and stored bytes of the ring
  always_comb begin
    if (wr_ptr_r < rd_ptr_r) begin
      room = {1'b0, rd_ptr_r} - {1'b0, wr_ptr_r} - SIZE_W'(1);
    end else begin
      room = {1'b0, rd_ptr_r} + size_r - {1'b0, wr_ptr_r} - SIZE_W'(1);
    end
    if (rd_ptr_r <= wr_ptr_r) begin
      stored = {1'b0, wr_ptr_r} - {1'b0, rd_ptr_r};
    end else begin
      stored = {1'b0, wr_ptr_r} + size_r - {1'b0, rd_ptr_r};
    end
  end

  assign word_full = {rd_data_r, word_r[23:0]};
  assign wrem_dec  = wrem_r - LEN_W'(1);
  assign rrem_dec  = rrem_r - LEN_W'(1);

  // Clamp the size register write
  always_comb begin
    if (32'(cfg_wr_data) < SIZE_MIN) begin
      new_size = SIZE_W'(SIZE_MIN);
    end else if (32'(cfg_wr_data) > BUF_BYTES) begin
      new_size = SIZE_W'(BUF_BYTES);
    end else begin
      new_size = SIZE_W'(cfg_wr_data);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    size_nxt       = size_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    pw_nxt         = pw_r;
    pr_nxt         = pr_r;
    wrem_nxt       = wrem_r;
    rrem_nxt       = rrem_r;
    wact_nxt       = wact_r;
    ract_nxt       = ract_r;
    mw_nxt         = mw_r;
    mr_nxt         = mr_r;
    cur_nxt        = cur_r;
    word_nxt       = word_r;
    res_status_nxt = res_status_r;
    res_byte_nxt   = res_byte_r;
    res_lout_nxt   = res_lout_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    load_out       = 1'b0;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_wdata      = '0;
    do_clear       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && !cfg_wr_en) begin
          q_pop          = 1'b1;
          cur_nxt        = q_op;
          k_nxt          = '0;
          res_status_nxt = ST_OK;
          res_byte_nxt   = '0;
          res_lout_nxt   = '0;
          res_last_nxt   = 1'b0;
          state_nxt      = S_RESULT;
          unique case (q_op.op)
            OP_WBEGIN: begin
              if (wact_r) begin
                res_status_nxt = ST_SEQ_ERR;
              end else if (SIZE_W'(q_op.msg_length) + SIZE_W'(FRAME_BYTES) > room) begin
                res_status_nxt = ST_FULL;
              end else begin
                pw_nxt    = wr_ptr_r;
                wrem_nxt  = q_op.msg_length;
                wact_nxt  = 1'b1;
                state_nxt = S_WHDR;
              end
            end
            OP_WBYTE: begin
              if (!wact_r) begin
                res_status_nxt = ST_SEQ_ERR;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = q_op.data_byte;
                pw_nxt    = next_pos(pw_r, size_r);
                wrem_nxt  = wrem_dec;
                if (wrem_dec == '0) begin
                  state_nxt = S_WTRL;
                end
              end
            end
            OP_RBEGIN: begin
              if (ract_r) begin
                res_status_nxt = ST_SEQ_ERR;
              end else if (stored < SIZE_W'(FRAME_BYTES)) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                pr_nxt    = rd_ptr_r;
                state_nxt = S_RHDR;
              end
            end
            OP_RBYTE: begin
              if (!ract_r) begin
                res_status_nxt = ST_SEQ_ERR;
              end else begin
                // the read of pr_r is issued this cycle
                pr_nxt    = next_pos(pr_r, size_r);
                rrem_nxt  = rrem_dec;
                state_nxt = S_RBYTE;
              end
            end
            OP_CLEAR: begin
              do_clear = 1'b1;
            end
            default: begin
              res_status_nxt = ST_SEQ_ERR;
            end
          endcase
        end
      end

      // Write the little-endian length, one byte a cycle
      S_WHDR: begin
        mem_we    = 1'b1;
        mem_wdata = BYTE_W'(WORD_W'(cur_r.msg_length) >> {k_r[1:0], 3'b000});
        pw_nxt    = next_pos(pw_r, size_r);
        k_nxt     = k_r + 3'd1;
        if (k_r == 3'd3) begin
          k_nxt     = '0;
          state_nxt = (cur_r.msg_length == '0) ? S_WTRL : S_RESULT;
        end
      end

      // Write the trailer and commit the message
      S_WTRL: begin
        mem_we    = 1'b1;
        mem_wdata = BYTE_W'(TRAILER >> {k_r[1:0], 3'b000});
        pw_nxt    = next_pos(pw_r, size_r);
        k_nxt     = k_r + 3'd1;
        if (k_r == 3'd3) begin
          k_nxt      = '0;
          wr_ptr_nxt = next_pos(pw_r, size_r);
          mw_nxt     = mw_r + CNT_W'(1);
          wact_nxt   = 1'b0;
          state_nxt  = S_RESULT;
        end
      end

      // Read the length word: issue four reads, collect each from the registered read data
      S_RHDR: begin
        k_nxt = k_r + 3'd1;
        if (k_r != 3'd4) begin
          pr_nxt = next_pos(pr_r, size_r);
        end
        case (k_r)
          3'd1:    word_nxt[7:0]   = rd_data_r;
          3'd2:    word_nxt[15:8]  = rd_data_r;
          3'd3:    word_nxt[23:16] = rd_data_r;
          default: word_nxt        = word_r;
        endcase
        if (k_r == 3'd4) begin
          k_nxt     = '0;
          state_nxt = S_RESULT;
          if ((word_full[WORD_W-1:LEN_W] != '0) ||
              (SIZE_W'(word_full[LEN_W-1:0]) + SIZE_W'(FRAME_BYTES) > stored)) begin
            do_clear       = 1'b1;
            res_status_nxt = ST_CORRUPT;
          end else begin
            res_lout_nxt = word_full[LEN_W-1:0];
            if (word_full[LEN_W-1:0] > cur_r.reader_capacity) begin
              res_status_nxt = ST_TOO_SMALL;
            end else begin
              rrem_nxt = word_full[LEN_W-1:0];
              ract_nxt = 1'b1;
              if (word_full[LEN_W-1:0] == '0) begin
                state_nxt = S_RTRL;
              end
            end
          end
        end
      end

      // Take the payload byte read last cycle
      S_RBYTE: begin
        res_byte_nxt = rd_data_r;
        k_nxt        = '0;
        state_nxt    = (rrem_r == '0) ? S_RTRL : S_RESULT;
      end

      // Read and check the trailer
      S_RTRL: begin
        k_nxt = k_r + 3'd1;
        if (k_r != 3'd4) begin
          pr_nxt = next_pos(pr_r, size_r);
        end
        case (k_r)
          3'd1:    word_nxt[7:0]   = rd_data_r;
          3'd2:    word_nxt[15:8]  = rd_data_r;
          3'd3:    word_nxt[23:16] = rd_data_r;
          default: word_nxt        = word_r;
        endcase
        if (k_r == 3'd4) begin
          k_nxt        = '0;
          ract_nxt     = 1'b0;
          res_last_nxt = 1'b1;
          state_nxt    = S_RESULT;
          if (word_full != TRAILER) begin
            do_clear       = 1'b1;
            res_status_nxt = ST_CORRUPT;
          end else begin
            rd_ptr_nxt = pr_r;
            mr_nxt     = mr_r + CNT_W'(1);
          end
        end
      end

      // Hand the result to the output register once it is free
      S_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Drop the ring contents on clear or size change
    if (do_clear || cfg_wr_en) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      pw_nxt     = '0;
      pr_nxt     = '0;
      wrem_nxt   = '0;
      rrem_nxt   = '0;
      wact_nxt   = 1'b0;
      ract_nxt   = 1'b0;
      mw_nxt     = '0;
      mr_nxt     = '0;
    end
    if (cfg_wr_en) begin
      size_nxt = new_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      size_r      <= SIZE_W'(BUF_BYTES);
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      pw_r        <= '0;
      pr_r        <= '0;
      wrem_r      <= '0;
      rrem_r      <= '0;
      wact_r      <= 1'b0;
      ract_r      <= 1'b0;
      mw_r        <= '0;
      mr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      size_r      <= size_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      pw_r        <= pw_nxt;
      pr_r        <= pr_nxt;
      wrem_r      <= wrem_nxt;
      rrem_r      <= rrem_nxt;
      wact_r      <= wact_nxt;
      ract_r      <= ract_nxt;
      mw_r        <= mw_nxt;
      mr_r        <= mr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    word_r       <= word_nxt;
    res_status_r <= res_status_nxt;
    res_byte_r   <= res_byte_nxt;
    res_lout_r   <= res_lout_nxt;
    res_last_r   <= res_last_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_byte_r   <= res_byte_r;
      out_lout_r   <= res_lout_r;
      out_last_r   <= res_last_r;
      out_wcnt_r   <= mw_r;
      out_rcnt_r   <= mr_r;
    end
  end

  // Single write port, registered read at the pending read pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pw_r] <= mem_wdata;
    end
    rd_data_r <= mem[pr_r];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.read_byte     = out_byte_r;
  assign out_ch.length_out    = out_lout_r;
  assign out_ch.last_byte     = out_last_r;
  assign out_ch.written_count = out_wcnt_r;
  assign out_ch.read_count    = out_rcnt_r;

endmodule
